[rtl/ppi_pkg.sv]
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, constants and arithmetic helpers of the particle pool.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int POOL_SIZE_DEFAULT = 64;
  localparam int CNT_W  = 7;
  localparam int LIFE_W = 24;
  localparam int DT_W   = 16;
  localparam int VEC_W  = 48;
  localparam int COMP_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIFE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SPAWN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_LIFE_RD,
    ST_LIFE_EV,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_INT_RD,
    ST_INT_VEL,
    ST_INT_POS,
    ST_EMIT,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load_item;
    logic       spawn_wr;
    logic       life_wr;
    logic       move_wr;
    logic       vel_step;
    logic       pos_wr;
    logic       dec_active;
    logic       inc_active;
    logic       inc_died;
    logic       set_move_src;
    logic       slot_inc;
    logic       slot_clr;
    logic       emit_load;
    logic       emit_empty;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic op_spawn;
    logic spawn_more;
    logic dies;
    logic slot_below;
    logic need_move;
    logic emit_last;
  } stat_t;

  // Round-half-up of a Q8.8 value times dt (24 fractional bits) back to Q8.8.
  function automatic logic signed [17:0] scale_round(input logic signed [33:0] prod);
    logic signed [34:0] q;
    begin
      q = {prod[33], prod} + 35'sd32768;
      scale_round = q[33:16];
    end
  endfunction

  function automatic logic [COMP_W-1:0] sat16(input logic signed [18:0] v);
    begin
      if (v > 19'sd32767) sat16 = 16'h7FFF;
      else if (v < -19'sd32768) sat16 = 16'h8000;
      else sat16 = v[15:0];
    end
  endfunction

endpackage

[rtl/ppi_ctrl.sv]
// ----------------------------------------------------------------------------
// ppi_ctrl
// Sequencer for spawn, the life/removal walk, integration and result output.
// ----------------------------------------------------------------------------
module ppi_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_ready,
  input  ppi_pkg::stat_t  stat,
  output ppi_pkg::ctrl_t  ctrl,
  output logic            busy,
  output logic            out_valid
);

  ppi_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ppi_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state)
      ppi_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          ctrl.load_item = 1'b1;
          ctrl.slot_clr = 1'b1;
          state_next = ppi_pkg::ST_SPAWN;
        end
      end
      ppi_pkg::ST_SPAWN: begin
        if (stat.op_spawn) begin
          if (stat.spawn_more) begin
            ctrl.spawn_wr = 1'b1;
            ctrl.inc_active = 1'b1;
          end else begin
            ctrl.emit_empty = 1'b1;
            state_next = ppi_pkg::ST_EMIT_WAIT;
          end
        end else begin
          state_next = ppi_pkg::ST_LIFE_RD;
        end
      end
      ppi_pkg::ST_LIFE_RD: begin
        if (stat.slot_below) begin
          state_next = ppi_pkg::ST_LIFE_EV;
        end else begin
          ctrl.slot_clr = 1'b1;
          state_next = ppi_pkg::ST_INT_RD;
        end
      end
      ppi_pkg::ST_LIFE_EV: begin
        if (stat.dies) begin
          ctrl.inc_died = 1'b1;
          ctrl.dec_active = 1'b1;
          if (stat.need_move) begin
            ctrl.set_move_src = 1'b1;
            state_next = ppi_pkg::ST_MOVE_RD;
          end else begin
            state_next = ppi_pkg::ST_LIFE_RD;
          end
        end else begin
          ctrl.life_wr = 1'b1;
          ctrl.slot_inc = 1'b1;
          state_next = ppi_pkg::ST_LIFE_RD;
        end
      end
      ppi_pkg::ST_MOVE_RD: state_next = ppi_pkg::ST_MOVE_WR;
      ppi_pkg::ST_MOVE_WR: begin
        ctrl.move_wr = 1'b1;
        state_next = ppi_pkg::ST_LIFE_RD;
      end
      ppi_pkg::ST_INT_RD: begin
        if (stat.slot_below) begin
          state_next = ppi_pkg::ST_INT_VEL;
        end else begin
          ctrl.slot_clr = 1'b1;
          state_next = ppi_pkg::ST_EMIT;
        end
      end
      ppi_pkg::ST_INT_VEL: begin
        ctrl.vel_step = 1'b1;
        state_next = ppi_pkg::ST_INT_POS;
      end
      ppi_pkg::ST_INT_POS: begin
        ctrl.pos_wr = 1'b1;
        ctrl.slot_inc = 1'b1;
        state_next = ppi_pkg::ST_INT_RD;
      end
      ppi_pkg::ST_EMIT: begin
        // Read the slot; the result register loads on the next cycle.
        if (stat.slot_below) begin
          state_next = ppi_pkg::ST_EMIT_LD;
        end else begin
          ctrl.emit_empty = 1'b1;
          state_next = ppi_pkg::ST_EMIT_WAIT;
        end
      end
      ppi_pkg::ST_EMIT_LD: begin
        ctrl.emit_load = 1'b1;
        state_next = ppi_pkg::ST_EMIT_WAIT;
      end
      ppi_pkg::ST_EMIT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.emit_last) state_next = ppi_pkg::ST_IDLE;
          else begin
            ctrl.slot_inc = 1'b1;
            state_next = ppi_pkg::ST_EMIT;
          end
        end
      end
      default: state_next = ppi_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/ppi_datapath.sv]
// ----------------------------------------------------------------------------
// ppi_datapath
// Particle stores, configuration registers, Euler step unit and result register.
// ----------------------------------------------------------------------------
module ppi_datapath #(
  parameter int POOL_SIZE = ppi_pkg::POOL_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ppi_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ppi_pkg::VEC_W-1:0]     cfg_data,
  input  logic                          in_op,
  input  logic [ppi_pkg::DT_W-1:0]      in_dt,
  input  logic [ppi_pkg::CNT_W-1:0]     in_count,
  input  ppi_pkg::ctrl_t                ctrl,
  output ppi_pkg::stat_t                stat,
  output logic                          o_has,
  output logic [5:0]                    o_index,
  output logic [3*ppi_pkg::COMP_W-1:0]  o_pos,
  output logic [ppi_pkg::LIFE_W-1:0]    o_life,
  output logic [ppi_pkg::CNT_W-1:0]     o_active,
  output logic [ppi_pkg::CNT_W-1:0]     o_died,
  output logic                          o_last
);

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [ppi_pkg::CNT_W-1:0] POOL_CNT = ppi_pkg::CNT_W'(POOL_SIZE);

  logic [ppi_pkg::VEC_W-1:0]  accel, speed, origin;
  logic [ppi_pkg::LIFE_W-1:0] life_init;
  logic [ppi_pkg::CNT_W-1:0]  pool_limit;

  logic [ppi_pkg::LIFE_W-1:0] life_mem [POOL_SIZE];
  logic [ppi_pkg::VEC_W-1:0]  pos_mem  [POOL_SIZE];
  logic [ppi_pkg::VEC_W-1:0]  vel_mem  [POOL_SIZE];

  logic [ppi_pkg::LIFE_W-1:0] life_rd;
  logic [ppi_pkg::VEC_W-1:0]  pos_rd, vel_rd, vel_new;

  logic [ppi_pkg::CNT_W-1:0] active, died, slot, target, move_src;
  logic                      op;
  logic [ppi_pkg::DT_W-1:0]  dt;
  logic                      move_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel <= '0;
      speed <= '0;
      origin <= '0;
      life_init <= ppi_pkg::LIFE_W'(65536);
      pool_limit <= POOL_CNT;
    end else if (cfg_we) begin
      case (cfg_addr)
        ppi_pkg::REG_ACCEL:  accel <= cfg_data;
        ppi_pkg::REG_SPEED:  speed <= cfg_data;
        ppi_pkg::REG_ORIGIN: origin <= cfg_data;
        ppi_pkg::REG_LIFE:   life_init <= cfg_data[ppi_pkg::LIFE_W-1:0];
        ppi_pkg::REG_LIMIT:  pool_limit <= cfg_data[ppi_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Spawn target: min(active + request, limit), limit capped at pool size.
  logic [ppi_pkg::CNT_W-1:0] lim_eff;
  logic [ppi_pkg::CNT_W:0]   sum_req;
  assign lim_eff = (pool_limit > POOL_CNT) ? POOL_CNT : pool_limit;
  assign sum_req = {1'b0, in_count} + {1'b0, active};

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      op <= in_op;
      dt <= in_dt;
      if (sum_req > {1'b0, lim_eff}) target <= lim_eff;
      else target <= sum_req[ppi_pkg::CNT_W-1:0];
    end
    if (ctrl.set_move_src) move_src <= active - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      died <= '0;
      slot <= '0;
      move_rd <= 1'b0;
    end else begin
      move_rd <= ctrl.set_move_src;
      if (ctrl.load_item) died <= '0;
      else if (ctrl.inc_died) died <= died + 1'b1;
      if (ctrl.inc_active) active <= active + 1'b1;
      else if (ctrl.dec_active) active <= active - 1'b1;
      if (ctrl.slot_clr) slot <= '0;
      else if (ctrl.slot_inc) slot <= slot + 1'b1;
    end
  end

  logic [ppi_pkg::VEC_W-1:0] vel_reg;

  // Euler step, one lane per component.
  logic [ppi_pkg::VEC_W-1:0] pos_new;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [15:0] a, v, p, s, vn;
      logic signed [33:0] pa, pv;
      a  = accel[16*k +: 16];
      v  = vel_rd[16*k +: 16];
      p  = pos_rd[16*k +: 16];
      s  = speed[16*k +: 16];
      pa = a * $signed({1'b0, dt});
      vel_new[16*k +: 16] = ppi_pkg::sat16(19'(v) + 19'(ppi_pkg::scale_round(pa)));
      vn = vel_reg[16*k +: 16];
      if (accel != '0) pv = vn * $signed({1'b0, dt});
      else pv = s * $signed({1'b0, dt});
      pos_new[16*k +: 16] = ppi_pkg::sat16(19'(p) + 19'(ppi_pkg::scale_round(pv)));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.vel_step) vel_reg <= (accel != '0) ? vel_new : vel_rd;
  end

  logic [AW-1:0] waddr;
  assign waddr = ctrl.spawn_wr ? AW'(active) : AW'(slot);

  // The read port follows the slot, except in the cycle that fetches the
  // particle moved into a freed slot.
  logic [AW-1:0] rd_addr;
  always_comb begin
    if (move_rd) rd_addr = AW'(move_src);
    else rd_addr = AW'(slot);
  end

  always_ff @(posedge clk) begin
    life_rd <= life_mem[rd_addr];
    pos_rd  <= pos_mem[rd_addr];
    vel_rd  <= vel_mem[rd_addr];
    if (ctrl.spawn_wr) begin
      life_mem[waddr] <= life_init;
      pos_mem[waddr]  <= origin;
      vel_mem[waddr]  <= speed;
    end else if (ctrl.life_wr) begin
      life_mem[waddr] <= life_rd - ppi_pkg::LIFE_W'(dt);
    end else if (ctrl.move_wr) begin
      life_mem[waddr] <= life_rd;
      pos_mem[waddr]  <= pos_rd;
      vel_mem[waddr]  <= vel_rd;
    end else if (ctrl.pos_wr) begin
      pos_mem[waddr] <= pos_new;
      vel_mem[waddr] <= vel_reg;
    end
  end

  // Result register, loaded in the cycle after the slot read.
  always_ff @(posedge clk) begin
    if (ctrl.emit_load) begin
      o_has <= 1'b1;
      o_index <= 6'(slot);
      o_pos <= pos_rd;
      o_life <= life_rd;
      o_active <= active;
      o_died <= died;
      o_last <= (slot + 1'b1 == active);
    end else if (ctrl.emit_empty) begin
      o_has <= 1'b0;
      o_index <= '0;
      o_pos <= '0;
      o_life <= '0;
      o_active <= active;
      o_died <= op ? '0 : died;
      o_last <= 1'b1;
    end
  end

  assign stat.op_spawn   = op;
  assign stat.spawn_more = active < target;
  assign stat.dies       = life_rd <= ppi_pkg::LIFE_W'(dt);
  assign stat.slot_below = slot < active;
  assign stat.need_move  = (active != 7'd1) && (active - 1'b1 != slot);
  assign stat.emit_last  = o_last;

endmodule

[rtl/particle_pool_integrator_core.sv]
// ----------------------------------------------------------------------------
// particle_pool_integrator_core
// Fixed-point particle pool with spawn, life expiry and Euler integration.
// ----------------------------------------------------------------------------
// Channel  | Dir | Content
// s_axis   | in  | tuser: op; tdata: dt[15:0], spawn_count[22:16]
// m_axis   | out | tuser: has; tdata: index, pos x/y/z, life, active, died; tlast
// cfg      | in  | cfg_we, cfg_addr (register index), cfg_data (48 bit)
//
// A spawn writes its new particles one by one. A tick walks the
// particles for the life check (a removal moves the last particle into
// the freed slot), integrates each survivor and then sends a result per
// particle. Reset clears the counters and restores the configuration
// defaults but not the memories; these are read only below the active
// count. Output stalls hold the sequencer in its result state.
module particle_pool_integrator_core #(
  parameter int POOL_SIZE = ppi_pkg::POOL_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ppi_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ppi_pkg::VEC_W-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // dt, spawn_count, zero fill
  input  logic                          s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // particle_index, pos_x, pos_y, pos_z, life_left,
  // active_count, died_count, zero fill
  output logic [95:0]                   m_axis_tdata,
  output logic                          m_axis_tuser,  // has_particle
  output logic                          m_axis_tlast
);

  ppi_pkg::ctrl_t ctrl;
  ppi_pkg::stat_t stat;
  logic busy, in_fire;
  logic o_has, o_last;
  logic [5:0] o_index;
  logic [47:0] o_pos;
  logic [23:0] o_life;
  logic [6:0] o_active, o_died;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  ppi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_ready(m_axis_tready),
    .stat(stat), .ctrl(ctrl), .busy(busy), .out_valid(m_axis_tvalid)
  );

  ppi_datapath #(.POOL_SIZE(POOL_SIZE)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_op(s_axis_tuser), .in_dt(s_axis_tdata[15:0]), .in_count(s_axis_tdata[22:16]),
    .ctrl(ctrl), .stat(stat), .o_has(o_has), .o_index(o_index), .o_pos(o_pos),
    .o_life(o_life), .o_active(o_active), .o_died(o_died), .o_last(o_last)
  );

  assign m_axis_tdata = {4'd0, o_died, o_active, o_life, o_pos, o_index};
  assign m_axis_tuser = o_has;
  assign m_axis_tlast = o_last;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
  a_last_has: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast) else $error("empty result not last");
  a_active_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[84:78] <= 7'(POOL_SIZE))) else $error("active over pool");

endmodule
